### hw/rtl/wvm_pkg.sv
// ----------------------------------------------------------------------------
// wvm_pkg
// Shared types and constants for the wavetable voice mixer: payload structs,
// configuration layout, operation codes and the command passed front to back.
// ----------------------------------------------------------------------------
package wvm_pkg;

    localparam int unsigned WVM_SAMPLE_DEPTH = 65536;
    localparam int unsigned WVM_QUEUE_DEPTH  = 4;

    localparam int unsigned WVM_CFG_IDX_W  = 3;
    localparam int unsigned WVM_CFG_DATA_W = 32;

    localparam logic [15:0] WVM_OFFSET_BIN   = 16'h8000;
    localparam logic [31:0] WVM_STEP_RESET   = 32'h0001_0000;
    localparam logic [5:0]  WVM_VOLUME_RESET = 6'd63;

    // Configuration register indexes.
    typedef enum logic [WVM_CFG_IDX_W-1:0] {
        CFG_STEP_INCREMENT    = 3'd0,
        CFG_FIRST_END         = 3'd1,
        CFG_LOOP_START        = 3'd2,
        CFG_LOOP_END          = 3'd3,
        CFG_LOOP_ENABLE       = 3'd4,
        CFG_VOICE_VOLUME      = 3'd5,
        CFG_OFFSET_BINARY_OUT = 3'd6
    } t_cfg_idx;

    // Operation codes; code 3 is unused and ignored.
    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_START = 2'd1,
        OP_TICK  = 2'd2
    } t_op;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] load_addr;
        logic [7:0]  load_byte;
        logic [15:0] acc_in;
    } t_in_item;

    typedef struct packed {
        logic [15:0] mix_out;
        logic        voice_active;
    } t_out_item;

    typedef struct packed {
        logic [31:0] step_increment;
        logic [31:0] first_end;
        logic [31:0] loop_start;
        logic [31:0] loop_end;
        logic        loop_enable;
        logic [5:0]  voice_volume;
        logic        offset_binary_out;
    } t_cfg;

    // One classified item on its way to the back end.
    typedef struct packed {
        logic        is_load;
        logic        is_tick;
        logic        mixing;
        logic [15:0] addr;
        logic [7:0]  data;
        logic [15:0] acc;
        logic        active;
    } t_cmd;

endpackage

### hw/rtl/wvm_queue.sv
// ----------------------------------------------------------------------------
// wvm_queue
// Small command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module wvm_queue
    import wvm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_cmd
);

    localparam int unsigned PTR_W = $clog2(WVM_QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(WVM_QUEUE_DEPTH + 1);

    t_cmd             r_slot [WVM_QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;

    assign o_full  = (r_count == CNT_W'(WVM_QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_slot[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(WVM_QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(WVM_QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(WVM_QUEUE_DEPTH))
        else $error("queue count exceeds depth");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("push without pop did not grow the queue");

    a_pop_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pop && !i_push) |=> (r_count == $past(r_count) - 1'b1))
        else $error("pop without push did not shrink the queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from an empty queue");

endmodule

### hw/rtl/wvm_front.sv
// ----------------------------------------------------------------------------
// wvm_front
// Accepts input beats, decodes the operation and keeps the voice position,
// end and playing flag. Each beat becomes one command for the back end.
// ----------------------------------------------------------------------------
module wvm_front
    import wvm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_in_item i_item,
    input  logic     i_full,
    output logic     o_push,
    output t_cmd     o_cmd
);

    logic [31:0] r_position;
    logic [31:0] r_end;
    logic        r_playing;
    logic [31:0] n_position;
    logic [31:0] n_end;
    logic        n_playing;
    logic [31:0] advanced;
    logic        accept;

    assign o_stall  = i_full;
    assign accept   = i_valid && !i_full;
    assign o_push   = accept;
    assign advanced = r_position + i_cfg.step_increment;

    always_comb begin
        n_position = r_position;
        n_end      = r_end;
        n_playing  = r_playing;
        case (i_item.op)
            OP_START: begin
                n_position = '0;
                n_end      = i_cfg.first_end;
                n_playing  = 1'b1;
            end
            OP_TICK: begin
                if (r_playing) begin
                    n_position = advanced;
                    // The position wraps at 32 bits before it meets the end.
                    if (advanced >= r_end) begin
                        if (i_cfg.loop_enable) begin
                            n_position = i_cfg.loop_start;
                            n_end      = i_cfg.loop_end;
                        end else begin
                            n_playing = 1'b0;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_cmd.is_load = (i_item.op == OP_LOAD);
        o_cmd.is_tick = (i_item.op == OP_TICK);
        o_cmd.mixing  = (i_item.op == OP_TICK) && r_playing;
        o_cmd.addr    = (i_item.op == OP_LOAD) ? i_item.load_addr : r_position[31:16];
        o_cmd.data    = i_item.load_byte;
        o_cmd.acc     = i_item.acc_in;
        o_cmd.active  = n_playing;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position <= '0;
            r_end      <= '0;
            r_playing  <= 1'b0;
        end else if (accept) begin
            r_position <= n_position;
            r_end      <= n_end;
            r_playing  <= n_playing;
        end
    end

    a_start_plays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_item.op == OP_START) |=> (r_playing && r_position == '0))
        else $error("start did not rewind and play");

    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !r_playing && i_item.op != OP_START)
        |=> (!r_playing && $stable(r_position) && $stable(r_end)))
        else $error("idle voice changed state");

    a_stop_only_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_playing && !n_playing) |-> (i_item.op == OP_TICK))
        else $error("voice stopped on a non-tick beat");

endmodule

### hw/rtl/wvm_back.sv
// ----------------------------------------------------------------------------
// wvm_back
// Executes commands: sample memory write or registered read, then the
// volume multiply and accumulator add into the output register.
// ----------------------------------------------------------------------------
module wvm_back
    import wvm_pkg::*;
#(
    parameter int unsigned SAMPLE_DEPTH = WVM_SAMPLE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_empty,
    input  t_cmd      i_cmd,
    output logic      o_pop,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_item
);

    // SAMPLE_DEPTH must be a power of two, which this block does not check; addresses wrap by truncation.
    localparam int unsigned ADDR_W = $clog2(SAMPLE_DEPTH);

    logic [7:0]        r_mem [SAMPLE_DEPTH];
    logic [7:0]        r_rd_data;
    logic              r_s1_valid;
    t_cmd              r_s1_cmd;
    logic              r_out_valid;
    t_out_item         r_out;
    logic              advance;
    logic [ADDR_W-1:0] addr;
    logic signed [7:0]  sample;
    logic signed [6:0]  volume;
    logic signed [14:0] product;
    logic [15:0]       contrib;
    logic [15:0]       mix;

    assign advance = !r_out_valid || !i_stall;
    assign o_pop   = advance && !i_empty;
    assign addr    = i_cmd.addr[ADDR_W-1:0];
    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            if (i_cmd.is_load) begin
                r_mem[addr] <= i_cmd.data;
            end
            r_rd_data <= r_mem[addr];
        end
    end

    always_comb begin
        sample  = r_rd_data;
        volume  = {1'b0, i_cfg.voice_volume};
        product = sample * volume;
        contrib = r_s1_cmd.mixing ? {product, 1'b0} : 16'd0;
        mix     = r_s1_cmd.acc + contrib
                  + (i_cfg.offset_binary_out ? WVM_OFFSET_BIN : 16'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_s1_valid  <= !i_empty;
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1_cmd           <= i_cmd;
            r_out.mix_out      <= r_s1_cmd.is_tick ? mix : 16'd0;
            r_out.voice_active <= r_s1_cmd.active;
        end
    end

    a_s1_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !advance) |=> r_s1_valid)
        else $error("pipeline dropped a command while stalled");

    a_s1_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && advance) |=> r_out_valid)
        else $error("command lost between stages");

    a_no_pop_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |-> !o_pop)
        else $error("queue popped while output stalled");

endmodule

### hw/rtl/wavetable_voice_mixer.sv
// ----------------------------------------------------------------------------
// wavetable_voice_mixer
// One chainable sample-playback voice with its own sample memory.
// ----------------------------------------------------------------------------
// The voice takes one beat per clock while o_in_stall is low and gives one
// result beat per input beat, in order. A beat passes the front end in its
// accept cycle, waits in a four-entry command queue, then is registered at
// the sample memory port (a load writes it, a tick reads it) together with
// its command, and goes through the volume multiply and accumulate into the
// output register. The single sample memory port sets the rate of one beat
// per cycle while neither side stalls. Input stall rises only when the
// queue is full. Configuration writes are taken on any cycle with
// i_cfg_we high and must be made while no beat is in flight.
// SAMPLE_DEPTH must be a power of two.
module wavetable_voice_mixer
    import wvm_pkg::*;
#(
    parameter int unsigned SAMPLE_DEPTH = WVM_SAMPLE_DEPTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [WVM_CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [WVM_CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  t_in_item                  i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output t_out_item                 o_out_data
);

    t_cfg r_cfg;
    t_cmd front_cmd;
    t_cmd queue_cmd;
    logic push;
    logic pop;
    logic full;
    logic empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_increment    <= WVM_STEP_RESET;
            r_cfg.first_end         <= '0;
            r_cfg.loop_start        <= '0;
            r_cfg.loop_end          <= '0;
            r_cfg.loop_enable       <= 1'b0;
            r_cfg.voice_volume      <= WVM_VOLUME_RESET;
            r_cfg.offset_binary_out <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_STEP_INCREMENT:    r_cfg.step_increment    <= i_cfg_wdata;
                CFG_FIRST_END:         r_cfg.first_end         <= i_cfg_wdata;
                CFG_LOOP_START:        r_cfg.loop_start        <= i_cfg_wdata;
                CFG_LOOP_END:          r_cfg.loop_end          <= i_cfg_wdata;
                CFG_LOOP_ENABLE:       r_cfg.loop_enable       <= i_cfg_wdata[0];
                CFG_VOICE_VOLUME:      r_cfg.voice_volume      <= i_cfg_wdata[5:0];
                CFG_OFFSET_BINARY_OUT: r_cfg.offset_binary_out <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    wvm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_item  (i_in_data),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (front_cmd)
    );

    wvm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_cmd   (queue_cmd)
    );

    wvm_back #(
        .SAMPLE_DEPTH (SAMPLE_DEPTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_empty (empty),
        .i_cmd   (queue_cmd),
        .o_pop   (pop),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_item  (o_out_data)
    );

endmodule

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the wavetable voice mixer. A short table of directed beats
// and register writes comes first. Random phases follow, each with its own
// register settings. Every accepted beat runs through a predictor of the
// voice, and each result beat is compared with the oldest expected result.
// ----------------------------------------------------------------------------
module tb_top
    import wvm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct {
        bit          is_cfg;
        t_cfg_idx    reg_idx;
        logic [31:0] reg_val;
        t_in_item    beat;
        bit          typed;
        t_out_item   want;
    } t_row;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    t_cfg_idx    cfg_idx;
    logic [31:0] cfg_wdata;
    logic        in_valid;
    logic        in_stall;
    t_in_item    in_data;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_out_item   out_data;

    // Predictor state of the voice.
    logic [7:0]  sample_mem [WVM_SAMPLE_DEPTH];
    bit          sample_written [WVM_SAMPLE_DEPTH];
    logic [31:0] voice_pos;
    logic [31:0] voice_end;
    logic        voice_playing;
    t_cfg        voice_cfg;

    t_out_item   mix_expected[$];
    t_row        directed_rows[$];
    int          mismatches = 0;
    bit          steady = 1'b0;

    wavetable_voice_mixer u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always #5 clk = ~clk;

    always @(negedge clk) begin
        out_stall <= !steady && ($urandom_range(0, 99) < 7);
    end

    task automatic flag_error(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic apply_reg(input t_cfg_idx idx, input logic [31:0] val);
        case (idx)
            CFG_STEP_INCREMENT:    voice_cfg.step_increment = val;
            CFG_FIRST_END:         voice_cfg.first_end = val;
            CFG_LOOP_START:        voice_cfg.loop_start = val;
            CFG_LOOP_END:          voice_cfg.loop_end = val;
            CFG_LOOP_ENABLE:       voice_cfg.loop_enable = val[0];
            CFG_VOICE_VOLUME:      voice_cfg.voice_volume = val[5:0];
            CFG_OFFSET_BINARY_OUT: voice_cfg.offset_binary_out = val[0];
            default: ;
        endcase
    endtask

    // Works out the result of one beat and advances the voice.
    task automatic predict_mix(input t_in_item b, output t_out_item r);
        logic signed [7:0] smp;
        int                contrib;
        logic [15:0]       acc;
        r = '0;
        acc = b.acc_in;
        case (b.op)
            OP_LOAD: begin
                sample_mem[b.load_addr] = b.load_byte;
                sample_written[b.load_addr] = 1'b1;
            end
            OP_START: begin
                voice_pos = '0;
                voice_end = voice_cfg.first_end;
                voice_playing = 1'b1;
            end
            OP_TICK: begin
                if (voice_playing) begin
                    smp = sample_mem[voice_pos[31:16]];
                    contrib = int'(smp) * int'(voice_cfg.voice_volume) * 2;
                    acc = acc + contrib[15:0];
                    // The position wraps at 32 bits before the end compare.
                    voice_pos = voice_pos + voice_cfg.step_increment;
                    if (voice_pos >= voice_end) begin
                        if (voice_cfg.loop_enable) begin
                            voice_pos = voice_cfg.loop_start;
                            voice_end = voice_cfg.loop_end;
                        end else begin
                            voice_playing = 1'b0;
                        end
                    end
                end
                if (voice_cfg.offset_binary_out) begin
                    acc = acc + WVM_OFFSET_BIN;
                end
                r.mix_out = acc;
            end
            default: ;
        endcase
        r.voice_active = voice_playing;
    endtask

    task automatic send_beat(input t_in_item b, input bit typed, input t_out_item want);
        t_out_item r;
        while (!steady && $urandom_range(0, 99) < 7) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= b;
        do @(posedge clk); while (in_stall);
        predict_mix(b, r);
        mix_expected.push_back(typed ? want : r);
    endtask

    // Stops sending and waits until the voice has nothing left in flight.
    task automatic drain_and_settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (mix_expected.size() != 0) @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        apply_reg(idx, val);
    endtask

    task automatic pick_settings(input bit extreme);
        logic [31:0] step, fend, lstart, lend;
        logic [5:0]  vol;
        if (extreme) begin
            step   = $urandom_range(0, 1) ? 32'hFFFF_FFFF
                                          : ($urandom_range(0, 1) ? 32'h0 : 32'h1);
            fend   = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
            lstart = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
            lend   = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
            vol    = $urandom_range(0, 1) ? 6'd63 : 6'd0;
        end else if ($urandom_range(0, 3) == 0) begin
            step   = $urandom;
            fend   = $urandom;
            lstart = $urandom;
            lend   = $urandom;
            vol    = 6'($urandom);
        end else begin
            // Short plays over a small window give many ends and loop wraps.
            step   = $urandom_range(32'h2000, 32'h3_0000);
            fend   = $urandom_range(0, 32'h18_FFFF);
            lstart = $urandom_range(0, 32'h10_0000);
            lend   = lstart + $urandom_range(0, 32'h10_0000);
            vol    = 6'($urandom_range(0, 63));
        end
        write_reg(CFG_STEP_INCREMENT, step);
        write_reg(CFG_FIRST_END, fend);
        write_reg(CFG_LOOP_START, lstart);
        write_reg(CFG_LOOP_END, lend);
        write_reg(CFG_LOOP_ENABLE, 32'($urandom_range(0, 1)));
        write_reg(CFG_VOICE_VOLUME, {26'd0, vol});
        write_reg(CFG_OFFSET_BINARY_OUT, 32'($urandom_range(0, 1)));
    endtask

    function automatic t_row beat_row(input logic [1:0] op, input logic [15:0] addr,
                                      input logic [7:0] data, input logic [15:0] acc,
                                      input bit typed = 1'b0, input logic [15:0] mix = '0,
                                      input logic act = 1'b0);
        t_row row;
        row = '{is_cfg: 1'b0, reg_idx: CFG_STEP_INCREMENT, reg_val: '0,
                beat: '0, typed: 1'b0, want: '0};
        row.beat = '{op: op, load_addr: addr, load_byte: data, acc_in: acc};
        row.typed = typed;
        row.want = '{mix_out: mix, voice_active: act};
        return row;
    endfunction

    function automatic t_row reg_row(input t_cfg_idx idx, input logic [31:0] val);
        t_row row;
        row = '{is_cfg: 1'b0, reg_idx: CFG_STEP_INCREMENT, reg_val: '0,
                beat: '0, typed: 1'b0, want: '0};
        row.is_cfg = 1'b1;
        row.reg_idx = idx;
        row.reg_val = val;
        return row;
    endfunction

    always @(posedge clk) begin : result_check
        t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            if (mix_expected.size() == 0) begin
                flag_error("result beat with nothing expected");
            end else begin
                want = mix_expected.pop_front();
                if (out_data.mix_out !== want.mix_out)
                    flag_error($sformatf("mix_out %h, expected %h",
                                         out_data.mix_out, want.mix_out));
                if (out_data.voice_active !== want.voice_active)
                    flag_error($sformatf("voice_active %b, expected %b",
                                         out_data.voice_active, want.voice_active));
            end
        end
    end

    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    initial begin : stimulus
        t_row     row;
        t_in_item b, fill;
        int       sel;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_idx   = CFG_STEP_INCREMENT;
        cfg_wdata = '0;
        in_valid  = 1'b0;
        in_data   = '0;
        voice_pos = '0;
        voice_end = '0;
        voice_playing = 1'b0;
        voice_cfg = '0;
        voice_cfg.step_increment = WVM_STEP_RESET;
        voice_cfg.voice_volume   = WVM_VOLUME_RESET;

        // Tick while idle, the unused code, loads at both address ends, a
        // first end of zero that stops the voice on its first tick.
        directed_rows.push_back(beat_row(OP_TICK, 16'h0, 8'h0, 16'h1234, 1, 16'h1234, 0));
        directed_rows.push_back(beat_row(OP_UNUSED, 16'hFFFF, 8'hFF, 16'hFFFF, 1, 16'h0, 0));
        directed_rows.push_back(beat_row(OP_LOAD, 16'h0000, 8'h80, 16'h0, 1, 16'h0, 0));
        directed_rows.push_back(beat_row(OP_LOAD, 16'hFFFF, 8'h7F, 16'h0, 1, 16'h0, 0));
        directed_rows.push_back(beat_row(OP_LOAD, 16'h0001, 8'hFF, 16'h0, 1, 16'h0, 0));
        directed_rows.push_back(beat_row(OP_LOAD, 16'h0002, 8'h00, 16'h0, 1, 16'h0, 0));
        directed_rows.push_back(beat_row(OP_START, 16'h0, 8'h0, 16'h0, 1, 16'h0, 1));
        directed_rows.push_back(beat_row(OP_UNUSED, 16'h0, 8'h0, 16'h0, 1, 16'h0, 1));
        directed_rows.push_back(beat_row(OP_TICK, 16'h0, 8'h0, 16'h0, 1, 16'hC100, 0));
        // Three-sample play with offset binary output, then stop.
        directed_rows.push_back(reg_row(CFG_FIRST_END, 32'h0003_0000));
        directed_rows.push_back(reg_row(CFG_OFFSET_BINARY_OUT, 32'd1));
        directed_rows.push_back(beat_row(OP_START, 16'h0, 8'h0, 16'h0, 1, 16'h0, 1));
        directed_rows.push_back(beat_row(OP_TICK, 16'h0, 8'h0, 16'h0000));
        directed_rows.push_back(beat_row(OP_TICK, 16'h0, 8'h0, 16'hFFFF));
        directed_rows.push_back(beat_row(OP_TICK, 16'h0, 8'h0, 16'h7FFF));
        directed_rows.push_back(beat_row(OP_TICK, 16'h0, 8'h0, 16'h0, 1, 16'h8000, 0));
        // Largest step and ends: the position wraps and the loop takes over.
        directed_rows.push_back(reg_row(CFG_VOICE_VOLUME, 32'd0));
        directed_rows.push_back(reg_row(CFG_OFFSET_BINARY_OUT, 32'd0));
        directed_rows.push_back(reg_row(CFG_STEP_INCREMENT, 32'hFFFF_FFFF));
        directed_rows.push_back(reg_row(CFG_LOOP_ENABLE, 32'd1));
        directed_rows.push_back(reg_row(CFG_LOOP_START, 32'hFFFF_0000));
        directed_rows.push_back(reg_row(CFG_LOOP_END, 32'hFFFF_FFFF));
        directed_rows.push_back(reg_row(CFG_FIRST_END, 32'hFFFF_FFFF));
        directed_rows.push_back(beat_row(OP_START, 16'h0, 8'h0, 16'h0));
        directed_rows.push_back(beat_row(OP_TICK, 16'h0, 8'h0, 16'h5555));
        directed_rows.push_back(beat_row(OP_TICK, 16'h0, 8'h0, 16'hAAAA));
        directed_rows.push_back(beat_row(OP_LOAD, 16'hFFFE, 8'h40, 16'h0));
        // A step of zero holds the voice on one sample.
        directed_rows.push_back(reg_row(CFG_VOICE_VOLUME, 32'd63));
        directed_rows.push_back(reg_row(CFG_STEP_INCREMENT, 32'd0));
        directed_rows.push_back(beat_row(OP_TICK, 16'h0, 8'h0, 16'h0));

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.is_cfg) begin
                drain_and_settle();
                write_reg(row.reg_idx, row.reg_val);
            end else begin
                send_beat(row.beat, row.typed, row.want);
            end
        end

        for (int ph = 0; ph < 10; ph++) begin
            drain_and_settle();
            pick_settings(ph % 4 == 1);
            steady = (ph == 4);
            for (int k = 0; k < 200; k++) begin
                if (ph == 6 && k == 100) drain_and_settle();
                b.load_addr = 16'($urandom);
                b.load_byte = 8'($urandom);
                b.acc_in    = 16'($urandom);
                sel = $urandom_range(0, 99);
                if (sel < 8)       b.op = OP_START;
                else if (sel < 30) b.op = OP_LOAD;
                else if (sel < 33) b.op = OP_UNUSED;
                else               b.op = OP_TICK;
                // Never let a tick read a sample entry that was not loaded.
                if (b.op == OP_TICK && voice_playing &&
                    !sample_written[voice_pos[31:16]]) begin
                    fill = b;
                    fill.op = OP_LOAD;
                    fill.load_addr = voice_pos[31:16];
                    fill.load_byte = 8'($urandom);
                    send_beat(fill, 1'b0, '0);
                end
                send_beat(b, 1'b0, '0);
            end
        end
        steady = 1'b0;

        @(negedge clk);
        in_valid <= 1'b0;
        while (mix_expected.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### wavetable_voice_mixer.f
hw/rtl/wvm_pkg.sv
hw/rtl/wvm_queue.sv
hw/rtl/wvm_front.sv
hw/rtl/wvm_back.sv
hw/rtl/wavetable_voice_mixer.sv
sim/tb_top.sv
